[rtl/core/afalu_pkg.sv]
`timescale 1ns / 1ps

package afalu_pkg;

    // operation codes carried on the opcode port
    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBB   = 5'd3,
        OP_ANA   = 5'd4,
        OP_XRA   = 5'd5,
        OP_ORA   = 5'd6,
        OP_CMP   = 5'd7,
        OP_RLC   = 5'd8,
        OP_RRC   = 5'd9,
        OP_RAL   = 5'd10,
        OP_RAR   = 5'd11,
        OP_DAA   = 5'd12,
        OP_CMA   = 5'd13,
        OP_STC   = 5'd14,
        OP_CMC   = 5'd15,
        OP_INR   = 5'd16,
        OP_DCR   = 5'd17,
        OP_DAD   = 5'd18,
        OP_LDA   = 5'd19,
        OP_LDF   = 5'd20,
        OP_COND  = 5'd21
    } op_t;

    // condition codes in operand bits 2..0
    typedef enum logic [2:0] {
        COND_NZ = 3'd0,
        COND_Z  = 3'd1,
        COND_NC = 3'd2,
        COND_C  = 3'd3,
        COND_PO = 3'd4,
        COND_PE = 3'd5,
        COND_P  = 3'd6,
        COND_M  = 3'd7
    } cond_t;

    // flag byte bit positions
    localparam int unsigned FLAG_S  = 7;
    localparam int unsigned FLAG_Z  = 6;
    localparam int unsigned FLAG_AC = 4;
    localparam int unsigned FLAG_P  = 2;
    localparam int unsigned FLAG_CY = 0;

    localparam logic [7:0] FLAGS_SET_MASK = 8'h02;
    localparam logic [7:0] FLAGS_CLR_MASK = 8'h28;

    localparam logic [7:0] ACC_RESET   = 8'hFF;
    localparam logic [7:0] FLAGS_RESET = 8'hD7;

    localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
    localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
    localparam logic [3:0] BCD_MAX      = 4'd9;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  flags;
        logic [7:0]  op_result;
        logic [15:0] sum;
        logic        cond;
    } alu_res_t;

    // sign, zero and even parity of a byte placed in a flag byte
    function automatic logic [7:0] szp(input logic [7:0] v);
        logic [7:0] f;
        f = '0;
        f[FLAG_S] = v[7];
        f[FLAG_Z] = (v == 8'd0);
        f[FLAG_P] = ~^v;
        return f;
    endfunction

    function automatic logic [7:0] fix_flags(input logic [7:0] f);
        return (f | FLAGS_SET_MASK) & ~FLAGS_CLR_MASK;
    endfunction

endpackage

[rtl/core/afalu_alu.sv]
`timescale 1ns / 1ps

module afalu_alu
(
    input  logic [4:0]          opcode,
    input  logic [7:0]          operand,
    input  logic [15:0]         hl_value,
    input  logic [15:0]         pair_value,
    input  logic [7:0]          acc,
    input  logic [7:0]          flags,
    output afalu_pkg::alu_res_t res
);

    logic       cy;
    logic       is_sub;
    logic       is_daa;
    logic [7:0] add_b;
    logic       add_c;
    logic [8:0] add_r;
    logic       add_ac;
    logic [7:0] add_flags;
    logic [7:0] sub_flags;

    logic [3:0] lo_nib;
    logic [3:0] hi_nib;
    logic [7:0] daa_adj;
    logic       daa_cy;

    logic [16:0] dad_r;
    logic [7:0]  inr_r;
    logic [7:0]  dcr_r;

    logic [7:0] a_new;
    logic [7:0] f_new;
    logic [7:0] opres;
    logic [15:0] sum;
    logic        cond;

    assign cy     = flags[afalu_pkg::FLAG_CY];
    assign is_sub = (opcode == afalu_pkg::OP_SUB) || (opcode == afalu_pkg::OP_SBB)
                 || (opcode == afalu_pkg::OP_CMP);
    assign is_daa = (opcode == afalu_pkg::OP_DAA);

    // decimal adjust correction
    assign lo_nib = acc[3:0];
    assign hi_nib = acc[7:4];
    always_comb
    begin
        daa_adj = 8'd0;
        daa_cy  = cy;
        if (flags[afalu_pkg::FLAG_AC] || (lo_nib > afalu_pkg::BCD_MAX))
        begin
            daa_adj = afalu_pkg::DAA_LOW_ADJ;
        end
        if (cy || (hi_nib > afalu_pkg::BCD_MAX)
            || ((hi_nib >= afalu_pkg::BCD_MAX) && (lo_nib > afalu_pkg::BCD_MAX)))
        begin
            daa_adj = daa_adj | afalu_pkg::DAA_HIGH_ADJ;
            daa_cy  = 1'b1;
        end
    end

    // one shared 8-bit adder; subtract runs as a + ~v + !borrow
    always_comb
    begin
        if (is_daa)
        begin
            add_b = daa_adj;
            add_c = 1'b0;
        end
        else if (is_sub)
        begin
            add_b = ~operand;
            add_c = ~((opcode == afalu_pkg::OP_SBB) && cy);
        end
        else
        begin
            add_b = operand;
            add_c = (opcode == afalu_pkg::OP_ADC) && cy;
        end
    end

    assign add_r  = {1'b0, acc} + {1'b0, add_b} + {8'd0, add_c};
    assign add_ac = acc[4] ^ add_b[4] ^ add_r[4];

    always_comb
    begin
        add_flags = afalu_pkg::szp(add_r[7:0]);
        add_flags[afalu_pkg::FLAG_AC] = add_ac;
        sub_flags = add_flags;
        add_flags[afalu_pkg::FLAG_CY] = add_r[8];
        sub_flags[afalu_pkg::FLAG_CY] = ~add_r[8];
    end

    assign dad_r = {1'b0, hl_value} + {1'b0, pair_value};
    assign inr_r = operand + 8'd1;
    assign dcr_r = operand - 8'd1;

    always_comb
    begin
        a_new = acc;
        f_new = flags;
        opres = 8'd0;
        sum   = 16'd0;
        cond  = 1'b0;
        case (opcode)
            afalu_pkg::OP_ADD,
            afalu_pkg::OP_ADC:
            begin
                a_new = add_r[7:0];
                f_new = add_flags;
            end
            afalu_pkg::OP_SUB,
            afalu_pkg::OP_SBB:
            begin
                a_new = add_r[7:0];
                f_new = sub_flags;
            end
            afalu_pkg::OP_CMP:
            begin
                f_new = sub_flags;
            end
            afalu_pkg::OP_ANA:
            begin
                a_new = acc & operand;
                f_new = afalu_pkg::szp(acc & operand);
                f_new[afalu_pkg::FLAG_AC] = acc[3] | operand[3];
            end
            afalu_pkg::OP_XRA:
            begin
                a_new = acc ^ operand;
                f_new = afalu_pkg::szp(acc ^ operand);
            end
            afalu_pkg::OP_ORA:
            begin
                a_new = acc | operand;
                f_new = afalu_pkg::szp(acc | operand);
            end
            afalu_pkg::OP_RLC:
            begin
                a_new = {acc[6:0], acc[7]};
                f_new[afalu_pkg::FLAG_CY] = acc[7];
            end
            afalu_pkg::OP_RRC:
            begin
                a_new = {acc[0], acc[7:1]};
                f_new[afalu_pkg::FLAG_CY] = acc[0];
            end
            afalu_pkg::OP_RAL:
            begin
                a_new = {acc[6:0], cy};
                f_new[afalu_pkg::FLAG_CY] = acc[7];
            end
            afalu_pkg::OP_RAR:
            begin
                a_new = {cy, acc[7:1]};
                f_new[afalu_pkg::FLAG_CY] = acc[0];
            end
            afalu_pkg::OP_DAA:
            begin
                a_new = add_r[7:0];
                f_new = add_flags;
                f_new[afalu_pkg::FLAG_CY] = daa_cy;
            end
            afalu_pkg::OP_CMA:
            begin
                a_new = ~acc;
            end
            afalu_pkg::OP_STC:
            begin
                f_new[afalu_pkg::FLAG_CY] = 1'b1;
            end
            afalu_pkg::OP_CMC:
            begin
                f_new[afalu_pkg::FLAG_CY] = ~cy;
            end
            afalu_pkg::OP_INR:
            begin
                opres = inr_r;
                f_new = afalu_pkg::szp(inr_r);
                f_new[afalu_pkg::FLAG_CY] = cy;
                f_new[afalu_pkg::FLAG_AC] = (inr_r[3:0] == 4'h0);
            end
            afalu_pkg::OP_DCR:
            begin
                opres = dcr_r;
                f_new = afalu_pkg::szp(dcr_r);
                f_new[afalu_pkg::FLAG_CY] = cy;
                f_new[afalu_pkg::FLAG_AC] = (dcr_r[3:0] != 4'hF);
            end
            afalu_pkg::OP_DAD:
            begin
                sum = dad_r[15:0];
                f_new[afalu_pkg::FLAG_CY] = dad_r[16];
            end
            afalu_pkg::OP_LDA:
            begin
                a_new = operand;
            end
            afalu_pkg::OP_LDF:
            begin
                f_new = operand;
            end
            afalu_pkg::OP_COND:
            begin
                case (operand[2:0])
                    afalu_pkg::COND_NZ: cond = ~flags[afalu_pkg::FLAG_Z];
                    afalu_pkg::COND_Z:  cond =  flags[afalu_pkg::FLAG_Z];
                    afalu_pkg::COND_NC: cond = ~flags[afalu_pkg::FLAG_CY];
                    afalu_pkg::COND_C:  cond =  flags[afalu_pkg::FLAG_CY];
                    afalu_pkg::COND_PO: cond = ~flags[afalu_pkg::FLAG_P];
                    afalu_pkg::COND_PE: cond =  flags[afalu_pkg::FLAG_P];
                    afalu_pkg::COND_P:  cond = ~flags[afalu_pkg::FLAG_S];
                    afalu_pkg::COND_M:  cond =  flags[afalu_pkg::FLAG_S];
                    default:            cond = 1'b0;
                endcase
            end
            default:
            begin
                a_new = acc;
            end
        endcase
    end

    assign res.acc       = a_new;
    assign res.flags     = afalu_pkg::fix_flags(f_new);
    assign res.op_result = opres;
    assign res.sum       = sum;
    assign res.cond      = cond;

endmodule

[rtl/core/accumulator_flag_alu.sv]
`timescale 1ns / 1ps

// 8080-style accumulator and flag unit. One transaction per clock is sustained
// while the output side is not stalled; each transaction is captured in an
// input register, evaluated by a single pass of combinational logic against
// the held accumulator and flag byte, and written to the result register,
// which drives the outputs. The accumulator and flags are updated as the
// transaction moves into the result register, so the next transaction sees
// them at once. After reset A is 0xFF and F is 0xD7.

module accumulator_flag_alu
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  opcode,
    input  logic [7:0]  operand,
    input  logic [15:0] hl_value,
    input  logic [15:0] pair_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  acc_out,
    output logic [7:0]  flags_out,
    output logic [7:0]  op_result,
    output logic [15:0] sum_out,
    output logic        condition_met
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [4:0]  opcode_reg;
    logic [7:0]  operand_reg;
    logic [15:0] hl_reg;
    logic [15:0] pair_reg;

    logic [7:0]  acc_reg;
    logic [7:0]  flags_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    afalu_pkg::alu_res_t res_reg;
    afalu_pkg::alu_res_t res_next;

    logic advance;
    logic in_take;
    logic fire;

    // result register free or being drained this cycle
    assign advance  = ~out_valid_reg | ~out_stall;
    assign in_stall = in_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;
    assign fire     = in_valid_reg & advance;

    assign in_valid_next  = in_take | (in_valid_reg & ~advance);
    assign out_valid_next = fire | (out_valid_reg & ~advance);

    afalu_alu u_alu
    (
        .opcode     (opcode_reg),
        .operand    (operand_reg),
        .hl_value   (hl_reg),
        .pair_value (pair_reg),
        .acc        (acc_reg),
        .flags      (flags_reg),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= afalu_pkg::ACC_RESET;
            flags_reg     <= afalu_pkg::FLAGS_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                acc_reg   <= res_next.acc;
                flags_reg <= res_next.flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            opcode_reg  <= opcode;
            operand_reg <= operand;
            hl_reg      <= hl_value;
            pair_reg    <= pair_value;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign acc_out       = res_reg.acc;
    assign flags_out     = res_reg.flags;
    assign op_result     = res_reg.op_result;
    assign sum_out       = res_reg.sum;
    assign condition_met = res_reg.cond;

endmodule
